### rtl/core/lmlp_pkg.sv
`default_nettype none
package lmlp_pkg;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [15:0] CODE_ERROR_LIMIT  = 16'd100;
  localparam logic [15:0] CODE_FORMAT_LOW   = 16'd600;
  localparam logic [15:0] CODE_FORMAT_LIMIT = 16'd800;

  localparam logic [1:0] SEV_ERROR   = 2'd0;
  localparam logic [1:0] SEV_FORMAT  = 2'd1;
  localparam logic [1:0] SEV_WARNING = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    PH_LSTART     = 4'd0,
    PH_PATH       = 4'd1,
    PH_AFTERCOLON = 4'd2,
    PH_PATH2      = 4'd3,
    PH_LINE       = 4'd4,
    PH_COLB       = 4'd5,
    PH_COLE       = 4'd6,
    PH_PAREN      = 4'd7,
    PH_LETTER     = 4'd8,
    PH_CODE       = 4'd9,
    PH_SKIP       = 4'd10,
    PH_MSG        = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    CM_BLANK = 2'd0,
    CM_POS   = 2'd1,
    CM_NEG   = 2'd2,
    CM_DONE  = 2'd3
  } conv_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_payload_t;

  typedef struct packed {
    logic [19:0] line_number;
    logic [19:0] column_first;
    logic [20:0] column_after;
    logic [15:0] code_value;
    logic [1:0]  severity_class;
    logic [15:0] message_offset;
    logic [15:0] message_length;
    logic        subject_present;
    logic [15:0] subject_offset;
    logic [15:0] subject_length;
  } out_payload_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic       colon;
    logic       slash;
    logic       dash;
    logic       plus;
    logic       lparen;
    logic       rparen;
    logic       quote;
    logic       cr;
    logic       lf;
    logic       blank;
    logic       digit;
    logic [3:0] digit_val;
    logic       last;
  } class_beat_t;

endpackage
`default_nettype wire

### rtl/core/lmlp_stream_if.sv
`default_nettype none
interface lmlp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/lmlp_front.sv
`default_nettype none
module lmlp_front (
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire lmlp_pkg::in_payload_t  in_data,
  output logic                        q_valid,
  input  wire logic                   q_ready,
  output lmlp_pkg::class_beat_t       q_data
);

  logic [7:0] c;
  logic [7:0] dig;

  assign c = in_data.data_byte;
  assign dig = c - lmlp_pkg::CH_ZERO;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;

  always_comb begin
    q_data.colon     = (c == lmlp_pkg::CH_COLON);
    q_data.slash     = (c == lmlp_pkg::CH_SLASH) || (c == lmlp_pkg::CH_BSLASH);
    q_data.dash      = (c == lmlp_pkg::CH_DASH);
    q_data.plus      = (c == lmlp_pkg::CH_PLUS);
    q_data.lparen    = (c == lmlp_pkg::CH_LPAREN);
    q_data.rparen    = (c == lmlp_pkg::CH_RPAREN);
    q_data.quote     = (c == lmlp_pkg::CH_QUOTE);
    q_data.cr        = (c == lmlp_pkg::CH_CR);
    q_data.lf        = (c == lmlp_pkg::CH_LF);
    // space, and TAB through CR
    q_data.blank     = (c == lmlp_pkg::CH_SPACE) ||
                       ((c >= lmlp_pkg::CH_TAB) && (c <= lmlp_pkg::CH_CR));
    q_data.digit     = (c >= lmlp_pkg::CH_ZERO) && (c <= lmlp_pkg::CH_NINE);
    q_data.digit_val = dig[3:0];
    q_data.last      = in_data.last_byte;
  end

endmodule
`default_nettype wire

### rtl/core/lmlp_queue.sv
`default_nettype none
module lmlp_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_valid,
  output logic                        wr_ready,
  input  wire lmlp_pkg::class_beat_t  wr_data,
  output logic                        rd_valid,
  input  wire logic                   rd_ready,
  output lmlp_pkg::class_beat_t       rd_data
);

  localparam int AW = $clog2(lmlp_pkg::QUEUE_DEPTH);

  lmlp_pkg::class_beat_t entries [lmlp_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != (AW+1)'(lmlp_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(lmlp_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(lmlp_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/lmlp_back.sv
`default_nettype none
module lmlp_back #(
  parameter int POSITION_BITS = 16,
  parameter int NUMBER_BITS   = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  output logic                        q_ready,
  input  wire lmlp_pkg::class_beat_t  q_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output lmlp_pkg::out_payload_t      out_data
);

  typedef struct packed {
    logic [NUMBER_BITS-1:0] acc;
    lmlp_pkg::conv_mode_t   mode;
  } conv_t;

  // atoi-style step: skip blanks, one sign, digits, stop at anything else
  function automatic conv_t feed(input logic [NUMBER_BITS-1:0] acc,
                                 input lmlp_pkg::conv_mode_t mode,
                                 input lmlp_pkg::class_beat_t b);
    conv_t r;
    logic [NUMBER_BITS+3:0] prod;
    r.acc  = acc;
    r.mode = mode;
    prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (NUMBER_BITS+4)'(b.digit_val);
    unique case (mode)
      lmlp_pkg::CM_BLANK: begin
        if (!b.blank) begin
          if (b.plus) begin
            r.mode = lmlp_pkg::CM_POS;
          end else if (b.dash) begin
            r.mode = lmlp_pkg::CM_NEG;
          end else if (b.digit) begin
            r.acc  = NUMBER_BITS'(b.digit_val);
            r.mode = lmlp_pkg::CM_POS;
          end else begin
            r.mode = lmlp_pkg::CM_DONE;
          end
        end
      end
      lmlp_pkg::CM_POS: begin
        if (b.digit) begin
          r.acc = (prod[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) ? '1 : prod[NUMBER_BITS-1:0];
        end else begin
          r.mode = lmlp_pkg::CM_DONE;
        end
      end
      lmlp_pkg::CM_NEG: begin
        if (!b.digit) begin
          r.mode = lmlp_pkg::CM_DONE;
        end
      end
      lmlp_pkg::CM_DONE: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [19:0] sat20(input logic [NUMBER_BITS-1:0] v);
    return (33'(v) > 33'd1048575) ? 20'hFFFFF : 20'(v);
  endfunction

  function automatic logic [15:0] sat16(input logic [32:0] v);
    return (v > 33'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  lmlp_pkg::phase_t       phase, phase_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [NUMBER_BITS-1:0] acc, acc_next;
  lmlp_pkg::conv_mode_t   mode, mode_next;
  logic [NUMBER_BITS-1:0] line_val, line_val_next;
  logic [NUMBER_BITS-1:0] col_first, col_first_next;
  logic [NUMBER_BITS-1:0] col_last, col_last_next;
  logic [POSITION_BITS-1:0] msg_start, msg_start_next;
  logic [1:0]             qcount, qcount_next;
  logic [POSITION_BITS-1:0] subj_start, subj_start_next;
  logic [POSITION_BITS-1:0] subj_end, subj_end_next;

  conv_t fed, fed0;
  logic  emit;
  logic  empty_msg;
  logic  take;

  logic [POSITION_BITS-1:0] msg_off;
  logic [POSITION_BITS-1:0] msg_len;
  logic [POSITION_BITS-1:0] subj_len;
  logic                     present;
  logic [15:0]              code;
  lmlp_pkg::out_payload_t   result;

  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;

  always_comb begin
    fed  = feed(acc, mode, q_data);
    fed0 = feed('0, lmlp_pkg::CM_BLANK, q_data);

    phase_next      = phase;
    acc_next        = acc;
    mode_next       = mode;
    line_val_next   = line_val;
    col_first_next  = col_first;
    col_last_next   = col_last;
    msg_start_next  = msg_start;
    qcount_next     = qcount;
    subj_start_next = subj_start;
    subj_end_next   = subj_end;
    emit            = 1'b0;
    empty_msg       = 1'b0;

    unique case (phase)
      lmlp_pkg::PH_PATH: begin
        if (q_data.colon) begin
          phase_next = lmlp_pkg::PH_AFTERCOLON;
        end
      end
      lmlp_pkg::PH_AFTERCOLON: begin
        if (q_data.slash) begin
          // colon was a drive letter's
          phase_next = lmlp_pkg::PH_PATH2;
        end else if (q_data.colon) begin
          line_val_next = '0;
          acc_next      = '0;
          mode_next     = lmlp_pkg::CM_BLANK;
          phase_next    = lmlp_pkg::PH_COLB;
        end else begin
          acc_next   = fed0.acc;
          mode_next  = fed0.mode;
          phase_next = lmlp_pkg::PH_LINE;
        end
      end
      lmlp_pkg::PH_PATH2: begin
        if (q_data.colon) begin
          acc_next   = '0;
          mode_next  = lmlp_pkg::CM_BLANK;
          phase_next = lmlp_pkg::PH_LINE;
        end
      end
      lmlp_pkg::PH_LINE: begin
        if (q_data.colon) begin
          line_val_next = acc;
          acc_next      = '0;
          mode_next     = lmlp_pkg::CM_BLANK;
          phase_next    = lmlp_pkg::PH_COLB;
        end else begin
          acc_next  = fed.acc;
          mode_next = fed.mode;
        end
      end
      lmlp_pkg::PH_COLB: begin
        if (q_data.dash) begin
          col_first_next = acc;
          acc_next       = '0;
          mode_next      = lmlp_pkg::CM_BLANK;
          phase_next     = lmlp_pkg::PH_COLE;
        end else begin
          acc_next  = fed.acc;
          mode_next = fed.mode;
        end
      end
      lmlp_pkg::PH_COLE: begin
        if (q_data.colon) begin
          col_last_next = acc;
          phase_next    = lmlp_pkg::PH_PAREN;
        end else begin
          acc_next  = fed.acc;
          mode_next = fed.mode;
        end
      end
      lmlp_pkg::PH_PAREN: begin
        if (q_data.lparen) begin
          phase_next = lmlp_pkg::PH_LETTER;
        end
      end
      lmlp_pkg::PH_LETTER: begin
        acc_next   = '0;
        mode_next  = lmlp_pkg::CM_BLANK;
        phase_next = q_data.rparen ? lmlp_pkg::PH_SKIP : lmlp_pkg::PH_CODE;
      end
      lmlp_pkg::PH_CODE: begin
        if (q_data.rparen) begin
          mode_next  = lmlp_pkg::CM_DONE;
          phase_next = lmlp_pkg::PH_SKIP;
        end else begin
          acc_next  = fed.acc;
          mode_next = fed.mode;
        end
      end
      lmlp_pkg::PH_SKIP: begin
        qcount_next    = 2'd0;
        msg_start_next = pos + 1'b1;
        if (q_data.cr) begin
          emit       = 1'b1;
          empty_msg  = 1'b1;
          phase_next = lmlp_pkg::PH_LSTART;
        end else begin
          acc_next   = fed.acc;
          mode_next  = fed.mode;
          phase_next = lmlp_pkg::PH_MSG;
        end
      end
      lmlp_pkg::PH_MSG: begin
        if (q_data.cr) begin
          emit       = 1'b1;
          phase_next = lmlp_pkg::PH_LSTART;
        end else begin
          acc_next  = fed.acc;
          mode_next = fed.mode;
          if (q_data.quote && (qcount != 2'd2)) begin
            if (qcount == 2'd0) begin
              subj_start_next = pos + 1'b1;
            end else begin
              subj_end_next = pos;
            end
            qcount_next = qcount + 1'b1;
          end
        end
      end
      default: begin
        if (q_data.cr || q_data.lf) begin
          phase_next = lmlp_pkg::PH_LSTART;
        end else if (q_data.colon) begin
          phase_next = lmlp_pkg::PH_AFTERCOLON;
        end else begin
          phase_next = lmlp_pkg::PH_PATH;
        end
      end
    endcase

    pos_next = pos + 1'b1;

    if (q_data.last) begin
      phase_next      = lmlp_pkg::PH_LSTART;
      pos_next        = '0;
      acc_next        = '0;
      mode_next       = lmlp_pkg::CM_BLANK;
      line_val_next   = '0;
      col_first_next  = '0;
      col_last_next   = '0;
      msg_start_next  = '0;
      qcount_next     = 2'd0;
      subj_start_next = '0;
      subj_end_next   = '0;
    end
  end

  // result built from the state as it stands at the closing CR
  always_comb begin
    code     = sat16(33'(acc));
    // a CR right after ')' starts the message just past itself
    msg_off  = (phase == lmlp_pkg::PH_SKIP) ? (pos + 1'b1) : msg_start;
    msg_len  = pos - msg_start;
    subj_len = (qcount == 2'd1) ? (pos - subj_start) : (subj_end - subj_start);
    present  = !empty_msg && (qcount != 2'd0) && (subj_len != '0);

    result.line_number  = sat20(line_val);
    result.column_first = sat20(col_first);
    result.column_after = {1'b0, sat20(col_last)} + 21'd1;
    result.code_value   = code;
    if (code < lmlp_pkg::CODE_ERROR_LIMIT) begin
      result.severity_class = lmlp_pkg::SEV_ERROR;
    end else if ((code >= lmlp_pkg::CODE_FORMAT_LOW) &&
                 (code < lmlp_pkg::CODE_FORMAT_LIMIT)) begin
      result.severity_class = lmlp_pkg::SEV_FORMAT;
    end else begin
      result.severity_class = lmlp_pkg::SEV_WARNING;
    end
    result.message_offset  = 16'(msg_off);
    result.message_length  = empty_msg ? 16'd0 : sat16(33'(msg_len));
    result.subject_present = present;
    result.subject_offset  = present ? 16'(subj_start) : 16'd0;
    result.subject_length  = present ? sat16(33'(subj_len)) : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= lmlp_pkg::PH_LSTART;
      pos        <= '0;
      acc        <= '0;
      mode       <= lmlp_pkg::CM_BLANK;
      line_val   <= '0;
      col_first  <= '0;
      col_last   <= '0;
      msg_start  <= '0;
      qcount     <= 2'd0;
      subj_start <= '0;
      subj_end   <= '0;
    end else if (take) begin
      phase      <= phase_next;
      pos        <= pos_next;
      acc        <= acc_next;
      mode       <= mode_next;
      line_val   <= line_val_next;
      col_first  <= col_first_next;
      col_last   <= col_last_next;
      msg_start  <= msg_start_next;
      qcount     <= qcount_next;
      subj_start <= subj_start_next;
      subj_end   <= subj_end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

### rtl/core/lint_message_line_parser_top.sv
// Path: a closing CR accepted from the input is written to the queue, and is
// loaded into the output register when the back end takes it from the queue.
// Throughput: one byte per cycle unless the output stalls; the back end
// advances whenever the output register is empty or being taken, the front
// keeps filling a two-entry queue.
// Reset (rst, synchronous): parser returns to line start, position zero,
// queue and output register empty.
`default_nettype none
module lint_message_line_parser_top #(
  parameter int POSITION_BITS = 16,
  parameter int NUMBER_BITS   = 20
) (
  input  wire logic     clk,
  input  wire logic     rst,
  lmlp_stream_if.sink   in_ch,
  lmlp_stream_if.source out_ch
);

  logic                  f_valid;
  logic                  f_ready;
  lmlp_pkg::class_beat_t f_data;
  logic                  b_valid;
  logic                  b_ready;
  lmlp_pkg::class_beat_t b_data;
  logic                  in_ready;
  logic                  out_valid;
  lmlp_pkg::out_payload_t out_data;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  lmlp_front u_front (
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_data  (in_ch.data),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  lmlp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  lmlp_back #(
    .POSITION_BITS (POSITION_BITS),
    .NUMBER_BITS   (NUMBER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_data    (b_data),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
